// File: sv/ist_pkg.sv
// Shared constants and types for the interpolation search table.
`timescale 1ns / 1ps

package ist_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int KEY_W       = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int NUM_W       = IDX_W + KEY_W;
    localparam int STEP_W      = $clog2(IDX_W);

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [NUM_W-1:0] num_t;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

endpackage

// File: sv/ist_in_if.sv
// Input channel: write or search transactions.
`timescale 1ns / 1ps

interface ist_in_if;
    logic          valid;
    logic          ready;
    logic          func;
    ist_pkg::idx_t entry_index;
    ist_pkg::key_t key_value;

    modport source (output valid, func, entry_index, key_value, input ready);
    modport sink   (input valid, func, entry_index, key_value, output ready);
endinterface

// File: sv/ist_out_if.sv
// Result channel: found flag and position.
`timescale 1ns / 1ps

interface ist_out_if;
    logic          valid;
    logic          ready;
    logic          found;
    ist_pkg::idx_t position;

    modport source (output valid, found, position, input ready);
    modport sink   (input valid, found, position, output ready);
endinterface

// File: sv/ist_cfg_if.sv
// Configuration write channel for the entry count register.
`timescale 1ns / 1ps

interface ist_cfg_if;
    logic          valid;
    logic          ready;
    ist_pkg::cnt_t entry_count;

    modport source (output valid, entry_count, input ready);
    modport sink   (input valid, entry_count, output ready);
endinterface

// File: sv/interpolation_search_table.sv
// Interpolation search table: key store plus sequential search engine.
//
// Keys live in a single-port synchronous RAM (1024 x 8) with no reset or
// clearing pass; entries must be written before a search reads them. A write
// transaction stores its key in the cycle it is accepted. A search
// transaction runs interpolation search over entries 0 to entry_count-1
// (clamped to the table depth), one item at a time. Each probe uses three
// table reads on the one RAM port (left end, right end, probe point), a
// range check, one 10x8 multiply and a 10-step restoring divider; a probe
// with equal end keys skips the multiply and the divider. A search ends on
// a hit, when the range empties, or when the key falls outside the end
// keys. The result sits in an output register, so a new transaction is
// accepted while it waits; a search that finishes while that register is
// still full holds until it drains.
`timescale 1ns / 1ps

module interpolation_search_table (
    input  logic     clk,
    input  logic     rst_n,
    ist_cfg_if.sink  cfg,
    ist_in_if.sink   item,
    ist_out_if.source result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TOP,
        S_HI,
        S_CHK,
        S_MUL,
        S_DIV,
        S_POS,
        S_RDP,
        S_CMP,
        S_DONE
    } state_t;

    state_t state_reg;

    ist_pkg::key_t mem [ist_pkg::TABLE_DEPTH];
    ist_pkg::key_t rd_data_reg;
    ist_pkg::idx_t mem_addr;
    logic          mem_we;

    ist_pkg::cnt_t entry_count_reg;
    ist_pkg::cnt_t count_clamped;
    ist_pkg::cnt_t left_reg;
    ist_pkg::cnt_t rend_reg;
    ist_pkg::cnt_t right_wide;
    ist_pkg::key_t key_reg;
    ist_pkg::key_t lo_reg;
    ist_pkg::key_t diff_reg;
    ist_pkg::key_t den_reg;
    ist_pkg::idx_t span_reg;
    ist_pkg::key_t rem_reg;
    ist_pkg::idx_t quo_reg;
    logic [ist_pkg::STEP_W-1:0] step_reg;
    ist_pkg::idx_t pos_reg;
    ist_pkg::num_t product;
    logic [ist_pkg::KEY_W:0] trial;
    logic [ist_pkg::KEY_W:0] trial_diff;
    logic          trial_ge;

    logic          hit_reg;
    ist_pkg::idx_t hit_pos_reg;
    logic          out_valid_reg;
    logic          out_found_reg;
    ist_pkg::idx_t out_pos_reg;

    logic          in_fire;

    assign cfg.ready       = 1'b1;
    assign item.ready      = (state_reg == S_IDLE);
    assign result.valid    = out_valid_reg;
    assign result.found    = out_found_reg;
    assign result.position = out_pos_reg;

    assign in_fire = item.valid && item.ready;

    assign count_clamped = (entry_count_reg > ist_pkg::CNT_W'(ist_pkg::TABLE_DEPTH)) ?
                           ist_pkg::CNT_W'(ist_pkg::TABLE_DEPTH) : entry_count_reg;
    assign right_wide    = rend_reg - ist_pkg::CNT_W'(1);

    assign product    = ist_pkg::NUM_W'(span_reg) * ist_pkg::NUM_W'(diff_reg);
    assign trial      = {rem_reg, quo_reg[ist_pkg::IDX_W-1]};
    assign trial_ge   = (trial >= {1'b0, den_reg});
    assign trial_diff = trial - {1'b0, den_reg};

    always_comb
    begin
        mem_addr = pos_reg;
        mem_we   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                mem_addr = item.entry_index;
                mem_we   = in_fire && (item.func == ist_pkg::FUNC_WRITE);
            end
            S_TOP:   mem_addr = left_reg[ist_pkg::IDX_W-1:0];
            S_HI:    mem_addr = right_wide[ist_pkg::IDX_W-1:0];
            default: mem_addr = pos_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= item.key_value;
        end
        rd_data_reg <= mem[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            entry_count_reg <= '0;
            left_reg        <= '0;
            rend_reg        <= '0;
            key_reg         <= '0;
            lo_reg          <= '0;
            diff_reg        <= '0;
            den_reg         <= '0;
            span_reg        <= '0;
            rem_reg         <= '0;
            quo_reg         <= '0;
            step_reg        <= '0;
            pos_reg         <= '0;
            hit_reg         <= 1'b0;
            hit_pos_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_found_reg   <= 1'b0;
            out_pos_reg     <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                entry_count_reg <= cfg.entry_count;
            end

            if (out_valid_reg && result.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && (item.func == ist_pkg::FUNC_SEARCH))
                    begin
                        left_reg    <= '0;
                        rend_reg    <= count_clamped;
                        key_reg     <= item.key_value;
                        hit_reg     <= 1'b0;
                        hit_pos_reg <= '0;
                        state_reg   <= S_TOP;
                    end
                end
                S_TOP:
                begin
                    if (left_reg < rend_reg)
                    begin
                        state_reg <= S_HI;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_HI:
                begin
                    lo_reg    <= rd_data_reg;
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    diff_reg <= key_reg - lo_reg;
                    den_reg  <= rd_data_reg - lo_reg;
                    span_reg <= right_wide[ist_pkg::IDX_W-1:0] - left_reg[ist_pkg::IDX_W-1:0];
                    if ((key_reg < lo_reg) || (key_reg > rd_data_reg))
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (rd_data_reg == lo_reg)
                    begin
                        pos_reg   <= left_reg[ist_pkg::IDX_W-1:0];
                        state_reg <= S_RDP;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // quotient fits IDX_W bits, so the top bits start below den
                    rem_reg   <= product[ist_pkg::NUM_W-1:ist_pkg::IDX_W];
                    quo_reg   <= product[ist_pkg::IDX_W-1:0];
                    step_reg  <= ist_pkg::STEP_W'(ist_pkg::IDX_W - 1);
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    rem_reg <= trial_ge ? trial_diff[ist_pkg::KEY_W-1:0]
                                        : trial[ist_pkg::KEY_W-1:0];
                    quo_reg <= {quo_reg[ist_pkg::IDX_W-2:0], trial_ge};
                    if (step_reg == '0)
                    begin
                        state_reg <= S_POS;
                    end
                    else
                    begin
                        step_reg <= step_reg - ist_pkg::STEP_W'(1);
                    end
                end
                S_POS:
                begin
                    pos_reg   <= left_reg[ist_pkg::IDX_W-1:0] + quo_reg;
                    state_reg <= S_RDP;
                end
                S_RDP:
                begin
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (rd_data_reg == key_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_pos_reg <= pos_reg;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        if (rd_data_reg < key_reg)
                        begin
                            left_reg <= ist_pkg::CNT_W'(pos_reg) + ist_pkg::CNT_W'(1);
                        end
                        else
                        begin
                            rend_reg <= ist_pkg::CNT_W'(pos_reg);
                        end
                        state_reg <= S_TOP;
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || result.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_found_reg <= hit_reg;
                        out_pos_reg   <= hit_pos_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK) |-> (left_reg < rend_reg))
        else $error("probe range empty at range check");

    a_quo_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POS) |-> (quo_reg <= span_reg))
        else $error("interpolation quotient exceeds span");

    a_hit_in_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_found_reg) |->
            (ist_pkg::CNT_W'(out_pos_reg) < entry_count_reg))
        else $error("hit position outside searched entries");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !hit_reg) |-> (hit_pos_reg == '0))
        else $error("miss transaction carries nonzero position");
`endif

endmodule
